FILE: design/padded_integer_to_ascii_top_assert.svh
`ifndef PADDED_INTEGER_TO_ASCII_TOP_ASSERT_SVH
`define PADDED_INTEGER_TO_ASCII_TOP_ASSERT_SVH

// same-cycle implication
`define PIA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PIA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pia_pkg.sv
package pia_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int DIGIT_DEPTH        = 64;
    localparam int DIGIT_AW           = 6;
    localparam int MAX_CHARS          = 63;

    localparam logic [4:0] BASE_MIN   = 5'd2;
    localparam logic [4:0] BASE_MAX   = 5'd16;
    localparam logic [3:0] DIGIT_TEN  = 4'd10;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    typedef struct packed {
        logic start;
        logic load;
        logic negate;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
        logic q_nonzero;
    } div_stat_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d >= DIGIT_TEN)
        begin
            c = CHAR_A + {4'd0, d - DIGIT_TEN};
        end
        else
        begin
            c = CHAR_ZERO + {4'd0, d};
        end
        return c;
    endfunction

endpackage

FILE: design/padded_integer_to_ascii_top.sv
// Formats one number per item as ASCII text, most significant digit first, right-aligned
// by pad characters to the requested width, with a minus sign for negative values in
// signed mode. Digits come from a bit-serial restoring divider that produces one quotient
// bit per clock; a negative value is first made positive by a serial negation. Once the
// digits are stored, characters stream out at one per cycle, apart from idle gaps between
// sign, padding and digits. Characters are shown for one cycle with valid high and cannot
// be held off, so the receiver must take one every cycle; last marks the final one. busy
// stays high until the final character has been registered, and start is taken only while
// busy is low.
module padded_integer_to_ascii_top
    import pia_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] value,
    input  logic [4:0]  base,
    input  logic        signed_mode,
    input  logic [5:0]  width,
    input  logic [7:0]  pad_char,
    output logic        valid,
    output logic [7:0]  out_char,
    output logic        last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEG,
        S_DIV,
        S_SIGN1,
        S_PAD,
        S_SIGN2,
        S_FETCH,
        S_DIG
    } state_t;

    state_t                state_reg, state_next;
    logic [4:0]            base_reg, base_next;
    logic [5:0]            width_reg, width_next;
    logic [7:0]            pad_reg, pad_next;
    logic                  neg_reg, neg_next;
    logic [6:0]            nd_reg, nd_next;
    logic [5:0]            npad_reg, npad_next;
    logic [DIGIT_AW-1:0]   dig_idx_reg, dig_idx_next;
    logic [5:0]            ecnt_reg, ecnt_next;
    logic [7:0]            out_char_reg, out_char_next;
    logic                  last_reg, last_next;
    logic                  valid_reg, valid_next;

    logic [VALUE_BITS-1:0] load_value;
    logic [4:0]            base_sat;
    logic [6:0]            total;
    div_ctrl_t             dctl;
    div_stat_t             dstat;
    logic [3:0]            rem;
    logic                  mem_we;
    logic [DIGIT_AW-1:0]   raddr;
    logic [3:0]            rdata;
    logic                  emit;
    logic                  fin;
    logic [7:0]            ch;

    assign load_value = (VALUE_BITS)'(value);
    assign base_sat   = (base < BASE_MIN) ? BASE_MIN : ((base > BASE_MAX) ? BASE_MAX : base);
    assign total      = nd_reg + 7'd1 + {6'd0, neg_reg};
    assign raddr      = (state_reg == S_DIG) ? dig_idx_reg - 1'b1 : dig_idx_reg;

    pia_div #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (dctl),
        .load_value (load_value),
        .base       (base_reg),
        .stat       (dstat),
        .rem        (rem)
    );

    pia_digit_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (nd_reg[DIGIT_AW-1:0]),
        .wdata (rem),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        base_next     = base_reg;
        width_next    = width_reg;
        pad_next      = pad_reg;
        neg_next      = neg_reg;
        nd_next       = nd_reg;
        npad_next     = npad_reg;
        dig_idx_next  = dig_idx_reg;
        ecnt_next     = ecnt_reg;
        out_char_next = out_char_reg;
        last_next     = 1'b0;
        valid_next    = 1'b0;
        dctl          = '0;
        mem_we        = 1'b0;
        emit          = 1'b0;
        fin           = 1'b0;
        ch            = pad_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    base_next   = base_sat;
                    width_next  = width;
                    pad_next    = pad_char;
                    neg_next    = signed_mode & load_value[VALUE_BITS-1];
                    nd_next     = 7'd0;
                    ecnt_next   = 6'd0;
                    dctl.start  = 1'b1;
                    dctl.load   = 1'b1;
                    dctl.negate = signed_mode & load_value[VALUE_BITS-1];
                    state_next  = (signed_mode & load_value[VALUE_BITS-1]) ? S_NEG : S_DIV;
                end
            end
            S_NEG:
            begin
                if (dstat.done)
                begin
                    dctl.start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (dstat.done)
                begin
                    mem_we  = 1'b1;
                    nd_next = nd_reg + 7'd1;
                    if (dstat.q_nonzero && (nd_reg < 7'(DIGIT_DEPTH - 1)))
                    begin
                        dctl.start = 1'b1;
                    end
                    else
                    begin
                        npad_next    = ({1'b0, width_reg} > total)
                                       ? 6'({1'b0, width_reg} - total) : 6'd0;
                        dig_idx_next = nd_reg[DIGIT_AW-1:0];
                        state_next   = S_SIGN1;
                    end
                end
            end
            S_SIGN1:
            begin
                if (neg_reg && (pad_reg == CHAR_ZERO))
                begin
                    emit = 1'b1;
                    ch   = CHAR_MINUS;
                end
                state_next = S_PAD;
            end
            S_PAD:
            begin
                if (npad_reg != 6'd0)
                begin
                    emit      = 1'b1;
                    ch        = pad_reg;
                    npad_next = npad_reg - 6'd1;
                end
                else
                begin
                    state_next = S_SIGN2;
                end
            end
            S_SIGN2:
            begin
                if (neg_reg && (pad_reg != CHAR_ZERO))
                begin
                    emit = 1'b1;
                    ch   = CHAR_MINUS;
                end
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                state_next = S_DIG;
            end
            S_DIG:
            begin
                emit         = 1'b1;
                ch           = digit_char(rdata);
                fin          = (dig_idx_reg == '0);
                dig_idx_next = dig_idx_reg - 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (emit)
        begin
            valid_next    = 1'b1;
            out_char_next = ch;
            ecnt_next     = ecnt_reg + 6'd1;
            // character cap reached or final digit
            if (fin || (ecnt_reg == 6'(MAX_CHARS - 1)))
            begin
                last_next  = 1'b1;
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        width_reg    <= width_next;
        pad_reg      <= pad_next;
        neg_reg      <= neg_next;
        nd_reg       <= nd_next;
        npad_reg     <= npad_next;
        dig_idx_reg  <= dig_idx_next;
        ecnt_reg     <= ecnt_next;
        out_char_reg <= out_char_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign valid    = valid_reg;
    assign out_char = out_char_reg;
    assign last     = last_reg;

`include "padded_integer_to_ascii_top_assert.svh"

    `PIA_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy,
        "accepted item did not raise busy")
    `PIA_ASSERT_IMP(a_last_idle, clk, rst_n, valid && last, !busy,
        "still busy after final character")
    `PIA_ASSERT_IMP(a_mid_busy, clk, rst_n, valid && !last, busy,
        "went idle before final character")
    `PIA_ASSERT_IMP(a_valid_past, clk, rst_n, valid, $past(busy),
        "character without an item in progress")

endmodule

FILE: design/pia_div.sv
module pia_div
    import pia_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  div_ctrl_t             ctrl,
    input  logic [VALUE_BITS-1:0] load_value,
    input  logic [4:0]            base,
    output div_stat_t             stat,
    output logic [3:0]            rem
);

    localparam int CW = $clog2(VALUE_BITS);

    typedef enum logic [1:0] {
        M_IDLE,
        M_NEG,
        M_DIV
    } mode_t;

    mode_t                 mode_reg, mode_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] dvd_reg, dvd_next;
    logic [3:0]            rem_reg, rem_next;
    logic                  seen_reg, seen_next;
    logic                  nz_reg, nz_next;
    logic                  done_reg, done_next;
    logic [4:0]            trial;
    logic                  ge;
    logic                  neg_bit;

    assign trial   = {rem_reg, dvd_reg[VALUE_BITS-1]};
    assign ge      = trial >= base;
    assign neg_bit = seen_reg ? ~dvd_reg[0] : dvd_reg[0];

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        seen_next = seen_reg;
        nz_next   = nz_reg;
        done_next = 1'b0;
        case (mode_reg)
            M_IDLE:
            begin
                if (ctrl.start)
                begin
                    cnt_next  = CW'(VALUE_BITS - 1);
                    seen_next = 1'b0;
                    rem_next  = 4'd0;
                    nz_next   = 1'b0;
                    if (ctrl.load)
                    begin
                        dvd_next = load_value;
                    end
                    mode_next = ctrl.negate ? M_NEG : M_DIV;
                end
            end
            M_NEG:
            begin
                // serial two's complement, lsb first, rotating right
                dvd_next  = {neg_bit, dvd_reg[VALUE_BITS-1:1]};
                seen_next = seen_reg | dvd_reg[0];
            end
            M_DIV:
            begin
                // restoring division, one quotient bit per cycle
                dvd_next = {dvd_reg[VALUE_BITS-2:0], ge};
                rem_next = ge ? 4'(trial - base) : trial[3:0];
                nz_next  = nz_reg | ge;
            end
            default:
            begin
                mode_next = M_IDLE;
            end
        endcase
        if (mode_reg != M_IDLE)
        begin
            if (cnt_reg == '0)
            begin
                mode_next = M_IDLE;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        seen_reg <= seen_next;
        nz_reg   <= nz_next;
    end

    assign stat.done      = done_reg;
    assign stat.q_nonzero = nz_reg;
    assign rem            = rem_reg;

endmodule

FILE: design/pia_digit_mem.sv
module pia_digit_mem
    import pia_pkg::*;
(
    input  logic                clk,
    input  logic                we,
    input  logic [DIGIT_AW-1:0] waddr,
    input  logic [3:0]          wdata,
    input  logic [DIGIT_AW-1:0] raddr,
    output logic [3:0]          rdata
);

    logic [3:0] mem [DIGIT_DEPTH];
    logic [3:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
